// ----- hw/rtl/ufsc_pkg.sv -----
`timescale 1ns / 1ps

package ufsc_pkg;

   // Verdict codes carried on the result channel.
   localparam logic [1:0] VERDICT_UNDECIDED = 2'd0;
   localparam logic [1:0] VERDICT_DETECTED  = 2'd1;
   localparam logic [1:0] VERDICT_EXCLUDED  = 2'd2;

   // Connect handshake progress.
   localparam logic [1:0] HS_IDLE  = 2'd0;
   localparam logic [1:0] HS_SAVED = 2'd1;
   localparam logic [1:0] HS_REPLY = 2'd2;

   // Two-packet probe progress.
   localparam logic [1:0] PROBE_IDLE     = 2'd0;
   localparam logic [1:0] PROBE_SAVED    = 2'd1;
   localparam logic [1:0] PROBE_GAVE_UP  = 2'd3;

   // First-word signatures, bytes 0..3 read big endian (WORD_PING is bytes 4..7).
   localparam logic [31:0] WORD_ALL_ONES  = 32'hffffffff;
   localparam logic [31:0] WORD_SHORT_A   = 32'h3a180000;
   localparam logic [31:0] WORD_SHORT_B   = 32'h39180000;
   localparam logic [31:0] WORD_VS01      = 32'h56533031;
   localparam logic [31:0] WORD_DS        = 32'h01007364;
   localparam logic [31:0] WORD_PING      = 32'h70696e67;
   localparam logic [15:0] WORD_PROBE_TOP = 16'h0d1d;
   localparam logic [31:0] WORD_DICT_A    = 32'h02124c6c;
   localparam logic [31:0] WORD_DICT_B    = 32'h02125c6c;

   // Reset value of the exclusion threshold.
   localparam logic [7:0] PACKET_LIMIT_RESET = 8'd20;

   // Fixed strings compared byte by byte at fixed offsets.
   localparam logic [7:0] CONNECT_STR [9] = '{
      8'h63, 8'h6f, 8'h6e, 8'h6e, 8'h65, 8'h63, 8'h74, 8'h30, 8'h78
   };
   localparam logic [7:0] LAN_STR [9] = '{
      8'h4c, 8'h61, 8'h6e, 8'h53, 8'h65, 8'h61, 8'h72, 8'h63, 8'h68
   };
   localparam logic [7:0] DICT_STR [32] = '{
      8'h6c, 8'h74, 8'h61, 8'h00, 8'h6d, 8'h6f, 8'h62, 8'h00,
      8'h74, 8'h70, 8'h63, 8'h00, 8'h62, 8'h68, 8'h6a, 8'h00,
      8'h62, 8'h78, 8'h64, 8'h00, 8'h74, 8'h61, 8'h65, 8'h00,
      8'h75, 8'h72, 8'h67, 8'h00, 8'h67, 8'h6b, 8'h68, 8'h00
   };

   // One input item as it travels through the match stage.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       is_udp;
      logic       dest_is_broadcast;
      logic [7:0] packet_count;
      logic [7:0] pos;
   } item_type;

endpackage

// ----- hw/rtl/udp_flow_signature_classifier_core.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | Handshake             | Payload
// req_      | in        | req_tvalid/req_tready | tdata, tlast, tuser
// rsp_      | out       | rsp_tvalid/rsp_tready | tdata
// csr_      | in        | csr_we                | csr_wdata (packet_limit)
//
// One byte is taken per cycle while req_tready is high; a verdict is registered in the output
// register when the last byte leaves the match stage. The token store is read at byte accept and
// compared while that byte is in the match stage, between the input and the output register.
// Reset is synchronous and active high and clears the flow state except the token
// store and the probe id, which are always written before they are read; no sweep runs.
// A stalled result holds the match stage only when that stage also holds a result.

module udp_flow_signature_classifier_core #(
   parameter int TOKEN_BYTES = 18
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] packet_count
   input  logic        req_tlast,   // last_byte
   input  logic [1:0]  req_tuser,   // [0] is_udp, [1] dest_is_broadcast
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [1:0] verdict, [7:2] zero
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   localparam int AW = (TOKEN_BYTES > 1) ? $clog2(TOKEN_BYTES) : 1;
   localparam logic [7:0] ECHO_LO = 8'd24;
   localparam logic [7:0] ECHO_HI = 8'(24 + TOKEN_BYTES);

   logic               accept, s1_go, out_free, has_result;
   logic               s1_valid_ff, s1_valid_in;
   ufsc_pkg::item_type item_ff;
   logic [7:0]         pos_ff, pos_in;
   logic [7:0]         limit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         verdict_ff, verdict;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [7:0]         rd_data, wr_data;
   logic               wr_en;

   // Handshake: the match stage moves unless its result has nowhere to go.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_go      = s1_valid_ff && (!has_result || out_free);
   assign req_tready = !s1_valid_ff || s1_go;
   assign accept     = req_tvalid && req_tready;

   // Input-side byte position of the arriving byte.
   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         if (!req_tuser[0] || req_tlast) begin
            pos_in = 8'd0;
         end else if (pos_ff != 8'd255) begin
            pos_in = pos_ff + 8'd1;
         end
      end
   end

   assign rd_addr = (pos_ff >= ECHO_LO && pos_ff < ECHO_HI) ? AW'(pos_ff - ECHO_LO) : '0;

   assign s1_valid_in  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_go && has_result) ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= 8'd0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= ufsc_pkg::PACKET_LIMIT_RESET;
      end else begin
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
   end

   // Payload registers of the match stage and the output.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.data_byte         <= req_tdata[7:0];
         item_ff.packet_count      <= req_tdata[15:8];
         item_ff.last_byte         <= req_tlast;
         item_ff.is_udp            <= req_tuser[0];
         item_ff.dest_is_broadcast <= req_tuser[1];
         item_ff.pos               <= pos_ff;
      end
      if (s1_go && has_result) begin
         verdict_ff <= verdict;
      end
   end

   ufsc_token_ram #(
      .DEPTH (TOKEN_BYTES),
      .AW    (AW)
   ) u_token_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ufsc_match_engine #(
      .TOKEN_BYTES (TOKEN_BYTES),
      .AW          (AW)
   ) u_match_engine (
      .clock         (clock),
      .reset         (reset),
      .item          (item_ff),
      .go            (s1_go),
      .packet_limit  (limit_ff),
      .token_rd_data (rd_data),
      .token_wr_en   (wr_en),
      .token_wr_addr (wr_addr),
      .token_wr_data (wr_data),
      .has_result    (has_result),
      .verdict       (verdict)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, verdict_ff};

   // The input side stalls only when both the match stage and the output are full.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a full pipeline");

   // A packet end or a non-UDP item restarts the byte position.
   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tlast || !req_tuser[0])) |=> pos_ff == 8'd0)
      else $error("byte position not restarted after packet end");

   // A new result only appears when the match stage hands one over.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid && !rsp_tready)) |-> $past(s1_go && has_result))
      else $error("result appeared without a match stage transfer");

endmodule

// ----- hw/rtl/ufsc_token_ram.sv -----
`timescale 1ns / 1ps

module ufsc_token_ram #(
   parameter int DEPTH = 18,
   parameter int AW    = 5
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ufsc_match_engine.sv -----
`timescale 1ns / 1ps

module ufsc_match_engine #(
   parameter int TOKEN_BYTES = 18,
   parameter int AW          = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  ufsc_pkg::item_type item,
   input  logic              go,
   input  logic [7:0]        packet_limit,
   input  logic [7:0]        token_rd_data,
   output logic              token_wr_en,
   output logic [AW-1:0]     token_wr_addr,
   output logic [7:0]        token_wr_data,
   output logic              has_result,
   output logic [1:0]        verdict
);

   localparam logic [7:0] TOK_SAVE_LO = 8'd5;
   localparam logic [7:0] TOK_SAVE_HI = 8'(5 + TOKEN_BYTES);
   localparam logic [7:0] TOK_ECHO_LO = 8'd24;
   localparam logic [7:0] TOK_ECHO_HI = 8'(24 + TOKEN_BYTES);
   localparam logic [7:0] POS_SAVE    = 8'(4 + TOKEN_BYTES);
   localparam logic [7:0] POS_REPLY   = 8'(23 + TOKEN_BYTES);

   logic [1:0]  hs_ff, hs_in;
   logic [1:0]  probe_ff, probe_in;
   logic [31:0] probe_id_ff, probe_id_in;
   logic [63:0] head_ff, head_in;
   logic [3:0]  flags_ff, flags_in;

   logic [63:0] head_base;
   logic [3:0]  flags_base;
   logic [31:0] w, w2, id;
   logic        excl, probe_hit, id_same;
   logic [7:0]  pos;

   assign pos = item.pos;

   // Per-byte capture of the head word and string match flags.
   always_comb begin
      head_base  = (pos == 8'd0) ? 64'd0 : head_ff;
      flags_base = (pos == 8'd0) ? 4'hf : flags_ff;
      head_in    = head_base;
      flags_in   = flags_base;
      for (int k = 0; k < 8; k++) begin
         if (pos == 8'(k)) begin
            head_in[63 - 8 * k -: 8] = item.data_byte;
         end
      end
      if (pos >= 8'd5 && pos < 8'd14 &&
          item.data_byte != ufsc_pkg::CONNECT_STR[4'(pos - 8'd5)]) begin
         flags_in[0] = 1'b0;
      end
      if (pos >= TOK_ECHO_LO && pos < TOK_ECHO_HI && item.data_byte != token_rd_data) begin
         flags_in[1] = 1'b0;
      end
      if (pos >= 8'd3 && pos < 8'd35 &&
          item.data_byte != ufsc_pkg::DICT_STR[5'(pos - 8'd3)]) begin
         flags_in[2] = 1'b0;
      end
      if (pos >= 8'd17 && pos < 8'd26 &&
          item.data_byte != ufsc_pkg::LAN_STR[4'(pos - 8'd17)]) begin
         flags_in[3] = 1'b0;
      end
   end

   // Token bytes are saved while no token is held yet.
   assign token_wr_en   = go && item.is_udp && hs_ff == ufsc_pkg::HS_IDLE &&
                          pos >= TOK_SAVE_LO && pos < TOK_SAVE_HI;
   assign token_wr_addr = AW'(pos - TOK_SAVE_LO);
   assign token_wr_data = item.data_byte;

   assign w         = head_in[63:32];
   assign w2        = head_in[31:0];
   assign id        = head_in[47:16];
   assign excl      = item.packet_count > packet_limit;
   assign probe_hit = probe_ff != ufsc_pkg::PROBE_GAVE_UP && w[31:16] == ufsc_pkg::WORD_PROBE_TOP;
   assign id_same   = probe_ff == ufsc_pkg::PROBE_SAVED && probe_id_ff == id;
   assign has_result = !item.is_udp || item.last_byte;

   // Verdict rules at the end of a packet, first rule that holds wins.
   always_comb begin
      hs_in       = hs_ff;
      probe_in    = probe_ff;
      probe_id_in = probe_id_ff;
      verdict     = excl ? ufsc_pkg::VERDICT_EXCLUDED : ufsc_pkg::VERDICT_UNDECIDED;
      if (!item.is_udp) begin
         verdict = excl ? ufsc_pkg::VERDICT_EXCLUDED : ufsc_pkg::VERDICT_UNDECIDED;
      end else if (pos < 8'd3) begin
         verdict = ufsc_pkg::VERDICT_UNDECIDED;
      end else if (hs_ff == ufsc_pkg::HS_IDLE && pos == POS_SAVE &&
                   w == ufsc_pkg::WORD_ALL_ONES && flags_in[0]) begin
         hs_in   = ufsc_pkg::HS_SAVED;
         verdict = ufsc_pkg::VERDICT_UNDECIDED;
      end else if (hs_ff == ufsc_pkg::HS_SAVED && pos >= POS_REPLY &&
                   w == ufsc_pkg::WORD_ALL_ONES && flags_in[1]) begin
         hs_in   = ufsc_pkg::HS_REPLY;
         verdict = ufsc_pkg::VERDICT_DETECTED;
      end else if (pos == 8'd7 &&
                   (w == ufsc_pkg::WORD_SHORT_A || w == ufsc_pkg::WORD_SHORT_B)) begin
         verdict = ufsc_pkg::VERDICT_DETECTED;
      end else if (pos >= 8'd35 && w == ufsc_pkg::WORD_VS01) begin
         verdict = ufsc_pkg::VERDICT_DETECTED;
      end else if (pos >= 8'd35 && w == ufsc_pkg::WORD_DS && w2 == ufsc_pkg::WORD_PING) begin
         verdict = ufsc_pkg::VERDICT_DETECTED;
      end else if (probe_hit && pos == 8'd12) begin
         verdict = ufsc_pkg::VERDICT_UNDECIDED;
         if (probe_ff == ufsc_pkg::PROBE_IDLE) begin
            probe_id_in = id;
            probe_in    = ufsc_pkg::PROBE_SAVED;
         end else if (!id_same) begin
            probe_in = ufsc_pkg::PROBE_GAVE_UP;
         end
      end else if (probe_hit && pos == 8'd14 && id_same) begin
         verdict = ufsc_pkg::VERDICT_DETECTED;
      end else begin
         // A probe-looking packet of any other shape ends the probe.
         if (probe_hit) begin
            probe_in = ufsc_pkg::PROBE_GAVE_UP;
         end
         if (pos >= 8'd139 && (w == ufsc_pkg::WORD_DICT_A || w == ufsc_pkg::WORD_DICT_B) &&
             flags_in[2]) begin
            verdict = ufsc_pkg::VERDICT_DETECTED;
         end else if (pos >= 8'd32 && item.dest_is_broadcast && flags_in[3]) begin
            verdict = ufsc_pkg::VERDICT_DETECTED;
         end
      end
   end

   // Flow state advances only when the item leaves the match stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff    <= ufsc_pkg::HS_IDLE;
         probe_ff <= ufsc_pkg::PROBE_IDLE;
         head_ff  <= 64'd0;
         flags_ff <= 4'd0;
      end else if (go && item.is_udp) begin
         head_ff  <= head_in;
         flags_ff <= flags_in;
         if (item.last_byte) begin
            hs_ff    <= hs_in;
            probe_ff <= probe_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go && item.is_udp && item.last_byte) begin
         probe_id_ff <= probe_id_in;
      end
   end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   localparam int TOKEN_BYTES = 18;
   localparam int CYCLE_LIMIT = 400000;

   // One payload byte or one non-UDP packet, as it is sent on the request channel.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       udp;
      logic       bcast;
      logic [7:0] count;
   } byte_item_type;

   typedef enum int {
      K_CONNECT, K_ECHO, K_SHORT, K_VS01, K_PING, K_PROBE_FIRST, K_PROBE_SECOND,
      K_DICT, K_LAN, K_NOISE, K_LONG
   } pkt_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;

   udp_flow_signature_classifier_core #(
      .TOKEN_BYTES(TOKEN_BYTES)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Pending request bytes and the verdicts they are predicted to produce.
   byte_item_type byte_queue [$];
   logic [1:0] verdict_queue [$];
   int         mismatch_count = 0;
   int         cycle_count = 0;
   bit         idle_enabled = 1'b1;
   bit         req_taken = 1'b0;
   int         req_gap = 0;
   int         rsp_gap = 0;

   // Shadow copy of the classifier state.
   logic [7:0]  limit_reg = ufsc_pkg::PACKET_LIMIT_RESET;
   logic [1:0]  hs_state = ufsc_pkg::HS_IDLE;
   logic [7:0]  token_store [TOKEN_BYTES];
   logic [1:0]  probe_st = ufsc_pkg::PROBE_IDLE;
   logic [31:0] probe_key = '0;
   logic [7:0]  byte_pos = '0;
   logic [63:0] head_word = '0;
   logic [3:0]  match_bits = '0;

   // Packet under construction and the values the generator aims at.
   logic [7:0]  pkt [$];
   logic [7:0]  sent_token [TOKEN_BYTES];
   logic [31:0] gen_probe_id;
   logic [7:0]  gen_limit = ufsc_pkg::PACKET_LIMIT_RESET;

   initial begin
      for (int i = 0; i < TOKEN_BYTES; i++) begin
         token_store[i] = 8'h00;
         sent_token[i] = 8'h00;
      end
   end

   function automatic logic [1:0] over_limit(input logic [7:0] count);
      return (count > limit_reg) ? ufsc_pkg::VERDICT_EXCLUDED : ufsc_pkg::VERDICT_UNDECIDED;
   endfunction

   // Rule chain applied at the last byte of a UDP packet of length len.
   function automatic logic [1:0] packet_verdict(input int len, input logic bcast,
                                                 input logic [7:0] count);
      logic [31:0] w;
      logic [31:0] w2;
      logic [31:0] id;
      w = head_word[63:32];
      w2 = head_word[31:0];
      id = head_word[47:16];
      if (len < 4)
         return ufsc_pkg::VERDICT_UNDECIDED;
      if (hs_state == ufsc_pkg::HS_IDLE && len == 5 + TOKEN_BYTES &&
          w == ufsc_pkg::WORD_ALL_ONES && match_bits[0]) begin
         hs_state = ufsc_pkg::HS_SAVED;
         return ufsc_pkg::VERDICT_UNDECIDED;
      end
      if (hs_state == ufsc_pkg::HS_SAVED && len >= 24 + TOKEN_BYTES &&
          w == ufsc_pkg::WORD_ALL_ONES && match_bits[1]) begin
         hs_state = ufsc_pkg::HS_REPLY;
         return ufsc_pkg::VERDICT_DETECTED;
      end
      if (len == 8 && (w == ufsc_pkg::WORD_SHORT_A || w == ufsc_pkg::WORD_SHORT_B))
         return ufsc_pkg::VERDICT_DETECTED;
      if (len >= 36 && w == ufsc_pkg::WORD_VS01)
         return ufsc_pkg::VERDICT_DETECTED;
      if (len >= 36 && w == ufsc_pkg::WORD_DS && w2 == ufsc_pkg::WORD_PING)
         return ufsc_pkg::VERDICT_DETECTED;
      // The probe rule ends the chain for 13-byte packets without an exclusion check.
      if (probe_st < ufsc_pkg::PROBE_GAVE_UP && w[31:16] == ufsc_pkg::WORD_PROBE_TOP) begin
         if (len == 13) begin
            if (probe_st == ufsc_pkg::PROBE_IDLE) begin
               probe_key = id;
               probe_st = ufsc_pkg::PROBE_SAVED;
               return ufsc_pkg::VERDICT_UNDECIDED;
            end
            if (probe_st == ufsc_pkg::PROBE_SAVED && probe_key == id)
               return ufsc_pkg::VERDICT_UNDECIDED;
            probe_st = ufsc_pkg::PROBE_GAVE_UP;
            return ufsc_pkg::VERDICT_UNDECIDED;
         end
         if (len == 15 && probe_st == ufsc_pkg::PROBE_SAVED && probe_key == id)
            return ufsc_pkg::VERDICT_DETECTED;
         probe_st = ufsc_pkg::PROBE_GAVE_UP;
      end
      if (len >= 140 && (w == ufsc_pkg::WORD_DICT_A || w == ufsc_pkg::WORD_DICT_B) &&
          match_bits[2])
         return ufsc_pkg::VERDICT_DETECTED;
      if (len >= 33 && bcast && match_bits[3])
         return ufsc_pkg::VERDICT_DETECTED;
      return over_limit(count);
   endfunction

   // Advances the shadow state by one accepted transfer; emits is set when a
   // verdict is due for it.
   task automatic predict_verdict(input byte_item_type it, output bit emits,
                                  output logic [1:0] verdict);
      int pos;
      emits = 1'b0;
      verdict = ufsc_pkg::VERDICT_UNDECIDED;
      if (!it.udp) begin
         byte_pos = '0;
         emits = 1'b1;
         verdict = over_limit(it.count);
         return;
      end
      pos = int'(byte_pos);
      if (pos == 0) begin
         head_word = '0;
         match_bits = 4'hf;
      end
      if (pos < 8)
         head_word[63 - 8 * pos -: 8] = it.data;
      if (pos >= 5 && pos < 14 && it.data != ufsc_pkg::CONNECT_STR[pos - 5])
         match_bits[0] = 1'b0;
      if (hs_state == ufsc_pkg::HS_IDLE && pos >= 5 && pos < 5 + TOKEN_BYTES)
         token_store[pos - 5] = it.data;
      if (pos >= 24 && pos < 24 + TOKEN_BYTES && it.data != token_store[pos - 24])
         match_bits[1] = 1'b0;
      if (pos >= 3 && pos < 35 && it.data != ufsc_pkg::DICT_STR[pos - 3])
         match_bits[2] = 1'b0;
      if (pos >= 17 && pos < 26 && it.data != ufsc_pkg::LAN_STR[pos - 17])
         match_bits[3] = 1'b0;
      if (pos < 255)
         byte_pos = 8'(pos + 1);
      if (!it.last)
         return;
      byte_pos = '0;
      emits = 1'b1;
      verdict = packet_verdict(pos + 1, it.bcast, it.count);
   endtask

   // Scoreboard: configuration shadow, verdict checks and request prediction.
   always @(posedge clock) begin
      byte_item_type item;
      bit         emits;
      logic [1:0] verdict;
      logic [1:0] wanted;
      if (!reset) begin
         if (csr_we)
            limit_reg = csr_wdata;
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected verdict transfer, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               wanted = verdict_queue.pop_front();
               if (rsp_tdata[1:0] !== wanted) begin
                  mismatch_count++;
                  $display("%0t: verdict mismatch, expected %0d, actual %0d",
                           $time, wanted, rsp_tdata[1:0]);
               end
               if (rsp_tdata[7:2] !== 6'd0) begin
                  mismatch_count++;
                  $display("%0t: padding mismatch, expected 0, actual %h",
                           $time, rsp_tdata[7:2]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            item = byte_queue.pop_front();
            predict_verdict(item, emits, verdict);
            if (emits)
               verdict_queue.push_back(verdict);
            req_taken = 1'b1;
         end
      end
   end

   // Request driver: holds a pending transfer until it is taken, idles in bursts.
   always @(negedge clock) begin
      if (req_tvalid && !req_taken) begin
         // Transfer still pending; keep it on the bus.
      end else if (req_gap > 0) begin
         req_gap--;
         req_tvalid <= 1'b0;
      end else if (byte_queue.size() > 0 && idle_enabled && $urandom_range(0, 9) == 0) begin
         req_gap = $urandom_range(1, 15) - 1;
         req_tvalid <= 1'b0;
      end else if (byte_queue.size() > 0) begin
         req_tvalid <= 1'b1;
         req_tdata <= {byte_queue[0].count, byte_queue[0].data};
         req_tlast <= byte_queue[0].last;
         req_tuser <= {byte_queue[0].bcast, byte_queue[0].udp};
      end else begin
         req_tvalid <= 1'b0;
      end
      req_taken = 1'b0;
   end

   // Result receiver: stalls in bursts.
   always @(negedge clock) begin
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(1, 15) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic build_random(input int len);
      pkt.delete();
      repeat (len) pkt.push_back(8'($urandom));
   endtask

   task automatic put_word(input int at, input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         pkt[at + i] = w[31 - 8 * i -: 8];
   endtask

   // Fills pkt with a packet shaped for the given signature.
   task automatic make_packet(input pkt_kind_type kind);
      case (kind)
         K_CONNECT: begin
            build_random(5 + TOKEN_BYTES);
            put_word(0, ufsc_pkg::WORD_ALL_ONES);
            for (int i = 0; i < 9; i++)
               pkt[5 + i] = ufsc_pkg::CONNECT_STR[i];
            for (int i = 0; i < TOKEN_BYTES; i++)
               sent_token[i] = pkt[5 + i];
         end
         K_ECHO: begin
            build_random(24 + TOKEN_BYTES + $urandom_range(0, 6));
            put_word(0, ufsc_pkg::WORD_ALL_ONES);
            for (int i = 0; i < TOKEN_BYTES; i++)
               pkt[24 + i] = sent_token[i];
         end
         K_SHORT: begin
            build_random(8);
            put_word(0, $urandom_range(0, 1) ? ufsc_pkg::WORD_SHORT_A : ufsc_pkg::WORD_SHORT_B);
         end
         K_VS01: begin
            build_random($urandom_range(36, 48));
            put_word(0, ufsc_pkg::WORD_VS01);
         end
         K_PING: begin
            build_random($urandom_range(36, 48));
            put_word(0, ufsc_pkg::WORD_DS);
            put_word(4, ufsc_pkg::WORD_PING);
         end
         K_PROBE_FIRST, K_PROBE_SECOND: begin
            build_random(kind == K_PROBE_FIRST ? 13 : 15);
            pkt[0] = ufsc_pkg::WORD_PROBE_TOP[15:8];
            pkt[1] = ufsc_pkg::WORD_PROBE_TOP[7:0];
            put_word(2, gen_probe_id);
         end
         K_DICT: begin
            build_random($urandom_range(140, 150));
            put_word(0, $urandom_range(0, 1) ? ufsc_pkg::WORD_DICT_A : ufsc_pkg::WORD_DICT_B);
            for (int i = 0; i < 32; i++)
               pkt[3 + i] = ufsc_pkg::DICT_STR[i];
         end
         K_LAN: begin
            build_random($urandom_range(33, 44));
            for (int i = 0; i < 9; i++)
               pkt[17 + i] = ufsc_pkg::LAN_STR[i];
         end
         K_LONG: build_random($urandom_range(255, 280));
         default: build_random($urandom_range(1, 40));
      endcase
   endtask

   // Queues pkt as UDP bytes; when cut, a non-UDP packet interrupts it part way.
   task automatic emit_packet(input logic bcast, input logic [7:0] count, input bit cut);
      byte_item_type it;
      int         n;
      n = pkt.size();
      if (cut && n > 1)
         n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) begin
         it.data = pkt[i];
         it.last = !cut && (i == n - 1);
         it.udp = 1'b1;
         it.bcast = bcast;
         it.count = count;
         byte_queue.push_back(it);
      end
      if (cut)
         push_other(count);
   endtask

   task automatic push_other(input logic [7:0] count);
      byte_item_type it;
      it.data = 8'($urandom);
      it.last = 1'($urandom);
      it.udp = 1'b0;
      it.bcast = 1'($urandom);
      it.count = count;
      byte_queue.push_back(it);
   endtask

   // Packet counts spread over the field and clustered around the threshold.
   function automatic logic [7:0] pick_count();
      int c;
      case ($urandom_range(0, 4))
         0: return 8'd0;
         1: return 8'd255;
         2: begin
            c = int'(gen_limit) + $urandom_range(0, 4) - 2;
            return (c < 0) ? 8'd0 : (c > 255) ? 8'd255 : 8'(c);
         end
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly signature packets with random content, some damaged, plus noise.
   task automatic queue_random_phase(input int target);
      int        start;
      int        k;
      int        idx;
      bit        cut;
      pkt_kind_type kind;
      start = byte_queue.size();
      while (byte_queue.size() - start < target) begin
         k = $urandom_range(0, 99);
         cut = 1'b0;
         if (k < 8) begin
            push_other(pick_count());
            continue;
         end
         if (k < 12) kind = K_CONNECT;
         else if (k < 16) kind = K_ECHO;
         else if (k < 26) kind = K_SHORT;
         else if (k < 32) kind = K_VS01;
         else if (k < 38) kind = K_PING;
         else if (k < 43) kind = K_PROBE_FIRST;
         else if (k < 47) kind = K_PROBE_SECOND;
         else if (k < 49) kind = K_DICT;
         else if (k < 58) kind = K_LAN;
         else if (k < 59) kind = K_LONG;
         else kind = K_NOISE;
         make_packet(kind);
         // Damage some packets: a wrong byte, one byte too many or too few, or a cut.
         case ($urandom_range(0, 9))
            0: begin
               idx = $urandom_range(0, pkt.size() - 1);
               pkt[idx] = pkt[idx] ^ 8'($urandom_range(1, 255));
            end
            1: pkt.push_back(8'($urandom));
            2: if (pkt.size() > 1) void'(pkt.pop_back());
            3: cut = 1'b1;
            default: ;
         endcase
         emit_packet(kind == K_LAN ? ($urandom_range(0, 4) != 0) : 1'($urandom),
                     pick_count(), cut);
      end
   endtask

   // Waits until the block has drained every expected verdict, plus its latency.
   task automatic wait_drained();
      while (byte_queue.size() != 0 || verdict_queue.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_limit(input logic [7:0] value);
      csr_wdata <= value;
      csr_we <= 1'b1;
      gen_limit = value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Stimulus sequence: directed packets, then random phases under several limits.
   initial begin
      logic [7:0] phase_limit [5];
      phase_limit[0] = 8'd0;
      phase_limit[1] = 8'd255;
      phase_limit[2] = 8'($urandom);
      phase_limit[3] = 8'($urandom_range(1, 30));
      phase_limit[4] = 8'($urandom);
      gen_probe_id = $urandom;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Packets shorter than four bytes never reach the exclusion check.
      for (int len = 1; len <= 3; len++) begin
         build_random(len);
         emit_packet(1'b1, 8'd255, 1'b0);
      end
      // Non-UDP packets on both sides of the reset threshold.
      push_other(8'd255);
      push_other(8'd20);
      push_other(8'd21);
      // Probe pair: saved id, repeated first packet, then the matching second.
      make_packet(K_PROBE_FIRST);
      emit_packet(1'b0, 8'd255, 1'b0);
      emit_packet(1'b0, 8'd255, 1'b0);
      make_packet(K_PROBE_SECOND);
      emit_packet(1'b0, 8'd255, 1'b0);
      // Connect token, then its echo in the reply.
      make_packet(K_CONNECT);
      emit_packet(1'b0, 8'd255, 1'b0);
      make_packet(K_ECHO);
      emit_packet(1'b0, 8'd255, 1'b0);
      // Fixed first-word signatures.
      build_random(8);
      put_word(0, ufsc_pkg::WORD_SHORT_A);
      emit_packet(1'b0, 8'd255, 1'b0);
      build_random(8);
      put_word(0, ufsc_pkg::WORD_SHORT_B);
      emit_packet(1'b0, 8'd255, 1'b0);
      make_packet(K_VS01);
      emit_packet(1'b0, 8'd255, 1'b0);
      make_packet(K_PING);
      emit_packet(1'b0, 8'd255, 1'b0);
      // LAN search with and without the broadcast destination.
      make_packet(K_LAN);
      emit_packet(1'b1, 8'd255, 1'b0);
      emit_packet(1'b0, 8'd21, 1'b0);
      // Plain packets at the threshold, and one cut short by a non-UDP packet.
      make_packet(K_NOISE);
      emit_packet(1'b0, 8'd20, 1'b0);
      emit_packet(1'b0, 8'd21, 1'b0);
      emit_packet(1'b0, 8'd0, 1'b1);

      for (int p = 0; p < 5; p++) begin
         wait_drained();
         if (p == 4)
            idle_enabled = 1'b0;
         write_limit(phase_limit[p]);
         queue_random_phase(120);
      end

      wait_drained();
      if (mismatch_count == 0 && verdict_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/ufsc_pkg.sv
hw/rtl/ufsc_token_ram.sv
hw/rtl/ufsc_match_engine.sv
hw/rtl/udp_flow_signature_classifier_core.sv
tb/testbench.sv
